// ----- src/dmac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dmac_pkg;

  // Item opcodes
  typedef enum logic [2:0] {
    OP_CFG     = 3'd0,
    OP_VBLANK  = 3'd1,
    OP_HBLANK  = 3'd2,
    OP_SPECIAL = 3'd3,
    OP_STEP    = 3'd4
  } opcode_t;

  // Address step modes
  localparam logic [1:0] STEP_INC    = 2'd0;
  localparam logic [1:0] STEP_DEC    = 2'd1;
  localparam logic [1:0] STEP_FIXED  = 2'd2;
  localparam logic [1:0] STEP_RELOAD = 2'd3;

  // Start timing modes
  localparam logic [1:0] TIM_NOW     = 2'd0;
  localparam logic [1:0] TIM_VBLANK  = 2'd1;
  localparam logic [1:0] TIM_HBLANK  = 2'd2;
  localparam logic [1:0] TIM_SPECIAL = 2'd3;

  localparam int          SPECIAL_CH  = 3;
  localparam int          ROM_BIT     = 27;
  localparam logic [31:0] SEEK_WORD   = 32'd4;
  localparam logic [31:0] SEEK_HALF   = 32'd2;
  localparam logic [1:0]  IDLE_NONSEQ = 2'd2;
  localparam int          QUEUE_DEPTH = 2;

  // Per-channel control bits
  typedef struct packed {
    logic       irq_req;
    logic       irq;
    logic [1:0] timing;
    logic       rpt;
    logic [1:0] tstep;
    logic [1:0] sstep;
    logic       word;
  } ctl_t;

  // Classified command passed from front to back
  typedef struct packed {
    opcode_t     op;
    logic [1:0]  channel;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [15:0] count;
    ctl_t        ctl;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic        transferred;
    logic [1:0]  served_channel;
    logic [31:0] read_addr;
    logic [31:0] write_addr;
    logic        is_word;
    logic        nonsequential;
    logic [1:0]  idle_cycles;
    logic        channel_irq;
    logic        cartridge_irq;
    logic        more_pending;
  } res_t;

endpackage

`default_nettype wire

// ----- src/dmac_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dmac_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [1:0]  channel;
  logic [31:0] source_addr;
  logic [31:0] target_addr;
  logic [15:0] unit_count;
  logic        word_size;
  logic [1:0]  source_step;
  logic [1:0]  target_step;
  logic        repeat_on;
  logic [1:0]  start_timing;
  logic        irq_on;
  logic        request_irq_on;

  modport source (
    output valid, opcode, channel, source_addr, target_addr, unit_count, word_size,
           source_step, target_step, repeat_on, start_timing, irq_on, request_irq_on,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, source_addr, target_addr, unit_count, word_size,
           source_step, target_step, repeat_on, start_timing, irq_on, request_irq_on,
    output ready
  );
endinterface

interface dmac_out_if;
  logic        valid;
  logic        ready;
  logic        transferred;
  logic [1:0]  served_channel;
  logic [31:0] read_addr;
  logic [31:0] write_addr;
  logic        is_word;
  logic        nonsequential;
  logic [1:0]  idle_cycles;
  logic        channel_irq;
  logic        cartridge_irq;
  logic        more_pending;

  modport source (
    output valid, transferred, served_channel, read_addr, write_addr, is_word,
           nonsequential, idle_cycles, channel_irq, cartridge_irq, more_pending,
    input  ready
  );
  modport sink (
    input  valid, transferred, served_channel, read_addr, write_addr, is_word,
           nonsequential, idle_cycles, channel_irq, cartridge_irq, more_pending,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/dmac_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmac_front import dmac_pkg::*; #(
  parameter int CHANNELS = 4
) (
  dmac_in_if.sink in_ch,
  input  logic    push_ready,
  output logic    push_valid,
  output cmd_t    push_cmd
);

  logic keep;

  // Drop unknown opcodes and configures of missing channels
  always_comb begin
    keep = 1'b0;
    unique case (in_ch.opcode)
      OP_CFG:                               keep = 32'(in_ch.channel) < CHANNELS;
      OP_VBLANK, OP_HBLANK, OP_SPECIAL, OP_STEP: keep = 1'b1;
      default:                              keep = 1'b0;
    endcase
  end

  // Pack the beat into a command
  always_comb begin
    push_cmd.op          = opcode_t'(in_ch.opcode);
    push_cmd.channel     = in_ch.channel;
    push_cmd.src         = in_ch.source_addr;
    push_cmd.tgt         = in_ch.target_addr;
    push_cmd.count       = in_ch.unit_count;
    push_cmd.ctl.irq_req = in_ch.request_irq_on;
    push_cmd.ctl.irq     = in_ch.irq_on;
    push_cmd.ctl.timing  = in_ch.start_timing;
    push_cmd.ctl.rpt     = in_ch.repeat_on;
    push_cmd.ctl.tstep   = in_ch.target_step;
    push_cmd.ctl.sstep   = in_ch.source_step;
    push_cmd.ctl.word    = in_ch.word_size;
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && keep;

endmodule

`default_nettype wire

// ----- src/dmac_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmac_queue import dmac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    priority if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- src/dmac_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dmac_back import dmac_pkg::*; #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  dmac_out_if.source out_ch
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [31:0]           rl_src_r  [CHANNELS];
  logic [31:0]           rl_src_nxt[CHANNELS];
  logic [31:0]           rl_tgt_r  [CHANNELS];
  logic [31:0]           rl_tgt_nxt[CHANNELS];
  logic [COUNT_BITS-1:0] rl_cnt_r  [CHANNELS];
  logic [COUNT_BITS-1:0] rl_cnt_nxt[CHANNELS];
  logic [31:0]           cur_src_r  [CHANNELS];
  logic [31:0]           cur_src_nxt[CHANNELS];
  logic [31:0]           cur_tgt_r  [CHANNELS];
  logic [31:0]           cur_tgt_nxt[CHANNELS];
  logic [COUNT_BITS-1:0] cur_cnt_r  [CHANNELS];
  logic [COUNT_BITS-1:0] cur_cnt_nxt[CHANNELS];
  ctl_t                  ctl_r  [CHANNELS];
  ctl_t                  ctl_nxt[CHANNELS];
  logic [CHANNELS-1:0]   en_r, en_nxt;
  logic [CHANNELS-1:0]   pending_r, pending_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r, res_nxt;

  logic [CH_W-1:0]       sel, ch_idx;
  logic                  any;
  ctl_t                  sctl;
  logic [31:0]           seek;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  blk_end, nonseq, rom2rom;

  assign ch_idx = CH_W'(head_cmd.channel);
  assign pop    = head_valid && (head_cmd.op != OP_STEP || !out_valid_r || out_ch.ready);

  // Pick the lowest pending channel
  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (pending_r[c]) begin
        sel = CH_W'(c);
        any = 1'b1;
      end
    end
  end

  // Per-transfer arithmetic for the selected channel
  assign sctl    = ctl_r[sel];
  assign seek    = sctl.word ? SEEK_WORD : SEEK_HALF;
  assign cnt_dec = cur_cnt_r[sel] - COUNT_BITS'(1);
  assign blk_end = cnt_dec == '0;
  assign nonseq  = cur_cnt_r[sel] == rl_cnt_r[sel];
  assign rom2rom = rl_src_r[sel][ROM_BIT] && rl_tgt_r[sel][ROM_BIT];

  // Execute the head command
  always_comb begin
    rl_src_nxt  = rl_src_r;
    rl_tgt_nxt  = rl_tgt_r;
    rl_cnt_nxt  = rl_cnt_r;
    cur_src_nxt = cur_src_r;
    cur_tgt_nxt = cur_tgt_r;
    cur_cnt_nxt = cur_cnt_r;
    ctl_nxt     = ctl_r;
    en_nxt      = en_r;
    pending_nxt = pending_r;
    res_nxt     = '0;
    if (pop) begin
      unique case (head_cmd.op)
        OP_CFG: begin
          rl_src_nxt[ch_idx]  = head_cmd.src;
          rl_tgt_nxt[ch_idx]  = head_cmd.tgt;
          rl_cnt_nxt[ch_idx]  = COUNT_BITS'(head_cmd.count);
          cur_src_nxt[ch_idx] = head_cmd.src;
          cur_tgt_nxt[ch_idx] = head_cmd.tgt;
          cur_cnt_nxt[ch_idx] = COUNT_BITS'(head_cmd.count);
          ctl_nxt[ch_idx]     = head_cmd.ctl;
          en_nxt[ch_idx]      = 1'b1;
          pending_nxt[ch_idx] = head_cmd.ctl.timing == TIM_NOW;
        end
        OP_VBLANK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (en_r[c] && ctl_r[c].timing == TIM_VBLANK) pending_nxt[c] = 1'b1;
          end
        end
        OP_HBLANK: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (en_r[c] && ctl_r[c].timing == TIM_HBLANK) pending_nxt[c] = 1'b1;
          end
        end
        OP_SPECIAL: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (c == SPECIAL_CH && en_r[c] && ctl_r[c].timing == TIM_SPECIAL) begin
              pending_nxt[c] = 1'b1;
            end
          end
        end
        OP_STEP: begin
          if (any) begin
            res_nxt.transferred    = 1'b1;
            res_nxt.served_channel = 2'(sel);
            res_nxt.read_addr      = cur_src_r[sel];
            res_nxt.write_addr     = cur_tgt_r[sel];
            res_nxt.is_word        = sctl.word;
            res_nxt.nonsequential  = nonseq;
            res_nxt.idle_cycles    = (nonseq && !rom2rom) ? IDLE_NONSEQ : 2'd0;
            // step the run addresses
            unique case (sctl.sstep)
              STEP_INC: cur_src_nxt[sel] = cur_src_r[sel] + seek;
              STEP_DEC: cur_src_nxt[sel] = cur_src_r[sel] - seek;
              default:  cur_src_nxt[sel] = cur_src_r[sel];
            endcase
            unique case (sctl.tstep)
              STEP_DEC:   cur_tgt_nxt[sel] = cur_tgt_r[sel] - seek;
              STEP_FIXED: cur_tgt_nxt[sel] = cur_tgt_r[sel];
              default:    cur_tgt_nxt[sel] = cur_tgt_r[sel] + seek;
            endcase
            cur_cnt_nxt[sel] = cnt_dec;
            // close the block
            if (blk_end) begin
              pending_nxt[sel] = 1'b0;
              if (sctl.tstep == STEP_RELOAD) cur_tgt_nxt[sel] = rl_tgt_r[sel];
              if (sctl.rpt) begin
                cur_cnt_nxt[sel] = rl_cnt_r[sel];
              end else begin
                en_nxt[sel] = 1'b0;
              end
            end
            res_nxt.channel_irq   = blk_end && sctl.irq;
            res_nxt.cartridge_irq = (32'(sel) == SPECIAL_CH) && sctl.irq_req;
            res_nxt.more_pending  = |pending_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the result until taken
  always_comb begin
    priority if (pop && head_cmd.op == OP_STEP) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rl_src_r[c]  <= '0;
        rl_tgt_r[c]  <= '0;
        rl_cnt_r[c]  <= '0;
        cur_src_r[c] <= '0;
        cur_tgt_r[c] <= '0;
        cur_cnt_r[c] <= '0;
        ctl_r[c]     <= '0;
      end
      en_r        <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rl_src_r    <= rl_src_nxt;
      rl_tgt_r    <= rl_tgt_nxt;
      rl_cnt_r    <= rl_cnt_nxt;
      cur_src_r   <= cur_src_nxt;
      cur_tgt_r   <= cur_tgt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      ctl_r       <= ctl_nxt;
      en_r        <= en_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop && head_cmd.op == OP_STEP) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.transferred    = res_r.transferred;
  assign out_ch.served_channel = res_r.served_channel;
  assign out_ch.read_addr      = res_r.read_addr;
  assign out_ch.write_addr     = res_r.write_addr;
  assign out_ch.is_word        = res_r.is_word;
  assign out_ch.nonsequential  = res_r.nonsequential;
  assign out_ch.idle_cycles    = res_r.idle_cycles;
  assign out_ch.channel_irq    = res_r.channel_irq;
  assign out_ch.cartridge_irq  = res_r.cartridge_irq;
  assign out_ch.more_pending   = res_r.more_pending;

  // A pending channel is always an enabled one
  a_pending_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r & ~en_r) == '0)
    else $error("pending channel is disabled");

  // An idle step result carries no addresses or pulses
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.transferred) |->
      (res_r.read_addr == '0 && res_r.write_addr == '0 &&
       !res_r.channel_irq && !res_r.cartridge_irq && !res_r.more_pending))
    else $error("idle step result not clear");

  // Cartridge pulse only comes from the special channel
  a_cart_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.cartridge_irq) |->
      (res_r.transferred && res_r.served_channel == 2'(SPECIAL_CH)))
    else $error("cartridge pulse from wrong channel");

  // A popped step always lands in the output slot
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_cmd.op == OP_STEP) |=> out_valid_r)
    else $error("step result lost");

endmodule

`default_nettype wire

// ----- src/four_channel_dma_controller_top.sv -----
// A step beat is written into the queue, then popped by the back stage into the output register.
// Throughput: one beat per cycle unless the queue fills; a two-entry queue lets
// the input side keep accepting while a result waits in the output register.
// Each step is one priority encode plus the source and target address updates in the back stage.
// Reset (synchronous, active low) clears all channel state, the queue pointers and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_dma_controller_top import dmac_pkg::*; #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  dmac_in_if.sink    in_ch,
  dmac_out_if.source out_ch
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic head_valid, pop;
  cmd_t head_cmd;

  // Classify incoming beats
  dmac_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // Decouple front and back
  dmac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Run the channels
  dmac_back #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
